@@ hw/rtl/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants of the color test pattern pixel unit
// Widths, register and format codes, reciprocal constants, bar color table.
// ----------------------------------------------------------------------------
package ctp_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int FMT_W   = 2;
	localparam int IDX_W   = 2;

	localparam logic [DIM_W-1:0] MAX_DIM    = 13'd4096;
	localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd1024;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd768;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_FORMAT = 2'd2;

	// pixel formats; any other code packs luma
	localparam logic [FMT_W-1:0] FMT_RGB32  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd1;

	// row regions
	localparam logic [1:0] REGION_BG   = 2'd0;
	localparam logic [1:0] REGION_BAR  = 2'd1;
	localparam logic [1:0] REGION_RAMP = 2'd2;
	localparam logic [1:0] REGION_GRAD = 2'd3;

	// ramp channel select
	localparam logic [1:0] SEL_R = 2'd0;
	localparam logic [1:0] SEL_G = 2'd1;
	localparam logic [1:0] SEL_B = 2'd2;

	// divider geometry: quotients are at most 255
	localparam int Q_BITS = 8;
	localparam int NLANE  = 3;
	localparam int DVD_W  = 21;
	localparam int DVS_W  = 13;
	localparam int LANE_V = 0;
	localparam int LANE_G = 1;
	localparam int LANE_B = 2;

	// reciprocal constants: n / d == (n * K) >> SH over the value ranges used
	localparam logic [18:0] DIV100_K  = 19'd335545;
	localparam int          DIV100_SH = 25;
	localparam logic [12:0] DIV9_K    = 13'd7282;
	localparam int          DIV9_SH   = 16;
	localparam logic [12:0] DIV3_K    = 13'd5462;
	localparam int          DIV3_SH   = 14;

	typedef struct packed {
		logic [DVD_W-1:0] dvd;
		logic [DVS_W-1:0] dvs;
	} div_lane_t;

	typedef struct packed {
		logic [FMT_W-1:0] fmt;
		logic             in_frame;
		logic             black;
		logic [1:0]       region;
		logic [3:0]       bar_idx;
		logic [1:0]       ramp_sel;
	} pix_side_t;

	// 0xRRGGBB of the nine bars
	function automatic logic [23:0] bar_rgb(input logic [3:0] idx);
		case (idx)
		4'd0: bar_rgb = 24'hFFFFFF;
		4'd1: bar_rgb = 24'h000000;
		4'd2: bar_rgb = 24'hFF0000;
		4'd3: bar_rgb = 24'h00FF00;
		4'd4: bar_rgb = 24'h0000FF;
		4'd5: bar_rgb = 24'hFFFF00;
		4'd6: bar_rgb = 24'hFF00FF;
		4'd7: bar_rgb = 24'h00FFFF;
		default: bar_rgb = 24'h808080; // gray bar
		endcase
	endfunction

endpackage

@@ hw/rtl/ctp_if.sv @@
// ----------------------------------------------------------------------------
// ctp_if: valid/ready channels of the color test pattern pixel unit
// Coordinate request channel and packed pixel result channel.
// ----------------------------------------------------------------------------
interface ctp_coord_if import ctp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ctp_pixel_if import ctp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic        in_frame;

	modport source (output valid, output pixel_word, output in_frame, input ready);
	modport sink (input valid, input pixel_word, input in_frame, output ready);
endinterface

@@ hw/rtl/ctp_div_pipe.sv @@
// ----------------------------------------------------------------------------
// ctp_div_pipe: pipelined restoring divider, three lanes, one quotient bit per stage
// Quotients are Q_BITS wide; sideband and valid travel with the lanes.
// ----------------------------------------------------------------------------
module ctp_div_pipe import ctp_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  div_lane_t [NLANE-1:0]          lanes_in,
	input  pix_side_t                      side_in,
	output logic                           out_vld,
	output logic [NLANE-1:0][Q_BITS-1:0]   quo,
	output pix_side_t                      side_out
);

	logic              vld_s  [Q_BITS];
	pix_side_t         side_s [Q_BITS];
	logic [DVD_W-1:0]  rem_s  [Q_BITS][NLANE];
	logic [DVS_W-1:0]  dvs_s  [Q_BITS][NLANE];
	logic [Q_BITS-1:0] quo_s  [Q_BITS][NLANE];

	for (genvar k = 0; k < Q_BITS; k++) begin : g_step
		logic              vld_in;
		pix_side_t         side_k;
		logic [DVD_W-1:0]  rem_in [NLANE];
		logic [DVS_W-1:0]  dvs_in [NLANE];
		logic [Q_BITS-1:0] quo_in [NLANE];

		if (k == 0) begin : g_head
			assign vld_in = in_vld;
			assign side_k = side_in;
			for (genvar l = 0; l < NLANE; l++) begin : g_lane
				assign rem_in[l] = lanes_in[l].dvd;
				assign dvs_in[l] = lanes_in[l].dvs;
				assign quo_in[l] = '0;
			end
		end else begin : g_body
			assign vld_in = vld_s[k-1];
			assign side_k = side_s[k-1];
			for (genvar l = 0; l < NLANE; l++) begin : g_lane
				assign rem_in[l] = rem_s[k-1][l];
				assign dvs_in[l] = dvs_s[k-1][l];
				assign quo_in[l] = quo_s[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_k;
			end
		end

		for (genvar l = 0; l < NLANE; l++) begin : g_sub
			logic [DVD_W-1:0] sh;
			logic             take;

			// divisor aligned to this stage's quotient bit
			assign sh   = DVD_W'(dvs_in[l]) << (Q_BITS - 1 - k);
			assign take = (rem_in[l] >= sh);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= take ? (rem_in[l] - sh) : rem_in[l];
					dvs_s[k][l] <= dvs_in[l];
					quo_s[k][l] <= {quo_in[l][Q_BITS-2:0], take};
				end
			end
		end
	end

	assign out_vld  = vld_s[Q_BITS-1];
	assign side_out = side_s[Q_BITS-1];
	for (genvar l = 0; l < NLANE; l++) begin : g_out
		assign quo[l] = quo_s[Q_BITS-1][l];
	end

endmodule

@@ hw/rtl/color_test_pattern_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// color_test_pattern_pixel_unit: test frame pixel generator
// Maps a pixel coordinate to the packed pixel word of a fixed test frame:
// color bars, RGB ramps, a 2D gradient, black border and separators.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------
//  coord    | in  | valid / ready | pixel_x[11:0], pixel_y[11:0]
//  pixel    | out | valid / ready | pixel_word[31:0], in_frame
//  wr_*     | in  | wr_en only    | wr_index[1:0], wr_data[12:0]
//
//  One transaction per clock while pixel.ready holds; 6 geometry stages, 8
//  divider stages and 2 color and packing stages lie between the input
//  transaction and output valid. The divider's one-bit-per-stage chain sets the depth.
//  A stall on pixel freezes the whole pipe (single advance enable); coord.ready
//  is low exactly while a finished result waits. Reset clears all valid bits
//  and loads the registers with 1024 x 768, RGB32.
//
module color_test_pattern_pixel_unit import ctp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [DIM_W-1:0] wr_data,
	ctp_coord_if.sink        coord,
	ctp_pixel_if.source      pixel
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [FMT_W-1:0] format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			format_q <= FMT_RGB32;
		end else if (wr_en) begin
			case (wr_index)
			REG_WIDTH:  width_q  <= wr_data;
			REG_HEIGHT: height_q <= wr_data;
			REG_FORMAT: format_q <= wr_data[FMT_W-1:0];
			default: ; // no register here
			endcase
		end
	end

	// dimensions clamp to the largest supported frame
	logic [DIM_W-1:0] w_sat;
	logic [DIM_W-1:0] h_sat;
	assign w_sat = (width_q > MAX_DIM) ? MAX_DIM : width_q;
	assign h_sat = (height_q > MAX_DIM) ? MAX_DIM : height_q;

	// ------------------------------------------------------------------
	// pipe control: one advance enable for every stage
	// ------------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s15, vld_s16;

	assign adv         = !vld_s16 || pixel.ready;
	assign coord.ready = adv;

	// ------------------------------------------------------------------
	// s1: capture coordinate together with the frame setup it applies to
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [DIM_W-1:0]   w_s1, h_s1;
	logic [FMT_W-1:0]   fmt_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= coord.pixel_x;
			y_s1   <= coord.pixel_y;
			w_s1   <= w_sat;
			h_s1   <= h_sat;
			fmt_s1 <= format_q;
		end
	end

	// ------------------------------------------------------------------
	// s2: constant products of the dimensions, frame test
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] x_s2, y_s2;
	logic [DIM_W-1:0]   w_s2, h_s2;
	logic [FMT_W-1:0]   fmt_s2;
	logic               infr_s2;
	logic [17:0]        h38_s2;  // h * 38
	logic [15:0]        h15_s2;  // h * 15
	logic [24:0]        bwm_s2;  // w * (2^16 / 9)
	logic [19:0]        xm_s2;   // x * 255
	logic [11:0]        wm1_s2;  // w - 1, never zero

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			fmt_s2  <= fmt_s1;
			infr_s2 <= ({1'b0, x_s1} < w_s1) && ({1'b0, y_s1} < h_s1);
			h38_s2  <= 18'(h_s1) * 18'd38;
			h15_s2  <= 16'(h_s1) * 16'd15;
			bwm_s2  <= 25'(w_s1) * 25'(DIV9_K);
			xm_s2   <= 20'(x_s1) * 20'd255;
			wm1_s2  <= (w_s1 <= 13'd1) ? 12'd1 : 12'(w_s1 - 13'd1);
		end
	end

	// ------------------------------------------------------------------
	// s3: bar height, ramp height, bar width (divide by reciprocal)
	// ------------------------------------------------------------------
	logic [35:0] bar_prod, ramp_prod;
	assign bar_prod  = 36'(h38_s2) * 36'(DIV100_K);
	assign ramp_prod = 36'(h15_s2) * 36'(DIV100_K);

	logic [COORD_W-1:0] x_s3, y_s3;
	logic [DIM_W-1:0]   w_s3, h_s3;
	logic [FMT_W-1:0]   fmt_s3;
	logic               infr_s3;
	logic [19:0]        xm_s3;
	logic [11:0]        wm1_s3;
	logic [10:0]        bar_h_s3;
	logic [9:0]         ramp_h_s3;
	logic [8:0]         bw_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			w_s3      <= w_s2;
			h_s3      <= h_s2;
			fmt_s3    <= fmt_s2;
			infr_s3   <= infr_s2;
			xm_s3     <= xm_s2;
			wm1_s3    <= wm1_s2;
			bar_h_s3  <= bar_prod[DIV100_SH +: 11];
			ramp_h_s3 <= ramp_prod[DIV100_SH +: 10];
			bw_s3     <= bwm_s2[DIV9_SH +: 9];
		end
	end

	// ------------------------------------------------------------------
	// s4: row boundaries, ramp thirds, bar column thresholds
	// ------------------------------------------------------------------
	logic [11:0] ramp_y0_c, ramp_end_c;
	logic [23:0] rt1_prod, rt2_prod;
	logic [11:0] thr_c [8];

	always_comb begin
		ramp_y0_c  = 12'(bar_h_s3) + 12'd40;
		ramp_end_c = ramp_y0_c + 12'(ramp_h_s3);
		rt1_prod   = 24'(ramp_h_s3) * 24'(DIV3_K);
		rt2_prod   = 24'({ramp_h_s3, 1'b0}) * 24'(DIV3_K);
		for (int k = 0; k < 8; k++) begin
			thr_c[k] = 12'(k + 1) * 12'(bw_s3); // left edge of bar k+1
		end
	end

	logic [COORD_W-1:0] x_s4, y_s4;
	logic [DIM_W-1:0]   w_s4, h_s4;
	logic [FMT_W-1:0]   fmt_s4;
	logic               infr_s4;
	logic [19:0]        xm_s4;
	logic [11:0]        wm1_s4;
	logic [10:0]        bar_h_s4;
	logic [8:0]         bw_s4;
	logic [11:0]        ramp_y0_s4, ramp_end_s4, grad_y0_s4;
	logic [8:0]         rt1_s4, rt2_s4;
	logic [11:0]        thr_s4 [8];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4        <= x_s3;
			y_s4        <= y_s3;
			w_s4        <= w_s3;
			h_s4        <= h_s3;
			fmt_s4      <= fmt_s3;
			infr_s4     <= infr_s3;
			xm_s4       <= xm_s3;
			wm1_s4      <= wm1_s3;
			bar_h_s4    <= bar_h_s3;
			bw_s4       <= bw_s3;
			ramp_y0_s4  <= ramp_y0_c;
			ramp_end_s4 <= ramp_end_c;
			grad_y0_s4  <= ramp_end_c + 12'd50;
			rt1_s4      <= rt1_prod[DIV3_SH +: 9];
			rt2_s4      <= rt2_prod[DIV3_SH +: 9];
			thr_s4      <= thr_c;
		end
	end

	// ------------------------------------------------------------------
	// s5: region decode, bar index, black overlay, gradient height
	// ------------------------------------------------------------------
	logic        grad_long_c;
	logic [11:0] grad_h_c;
	logic [12:0] grad_end_c;
	logic        in_bar_c, in_ramp_c, in_grad_c;
	logic [11:0] ry_c, gy_c, bar_sep_end_c;
	logic [1:0]  region_c, sel_c;
	logic [2:0]  bar_cnt_c;
	logic [3:0]  bar_idx_c;
	logic        black_c;

	always_comb begin
		grad_long_c = h_s4 > (13'(grad_y0_s4) + 13'd81);
		grad_h_c    = grad_long_c ? 12'(h_s4 - 13'(grad_y0_s4) - 13'd80) : 12'd1;
		grad_end_c  = grad_long_c ? (h_s4 - 13'd80) : (13'(grad_y0_s4) + 13'd1);

		in_bar_c  = y_s4 < 12'(bar_h_s4);
		in_ramp_c = (y_s4 >= ramp_y0_s4) && (y_s4 < ramp_end_s4);
		in_grad_c = (y_s4 >= grad_y0_s4) && (13'(y_s4) < grad_end_c);

		if (in_bar_c) begin
			region_c = REGION_BAR;
		end else if (in_ramp_c) begin
			region_c = REGION_RAMP;
		end else if (in_grad_c) begin
			region_c = REGION_GRAD;
		end else begin
			region_c = REGION_BG;
		end

		// ramp split in thirds of its height
		ry_c = y_s4 - ramp_y0_s4;
		if (ry_c < 12'(rt1_s4)) begin
			sel_c = SEL_R;
		end else if (ry_c < 12'(rt2_s4)) begin
			sel_c = SEL_G;
		end else begin
			sel_c = SEL_B;
		end

		// x / bw as a count of crossed thresholds; gray bar takes the rest
		bar_cnt_c = '0;
		for (int k = 0; k < 7; k++) begin
			bar_cnt_c = bar_cnt_c + 3'(x_s4 >= thr_s4[k]);
		end
		bar_idx_c = ((bw_s4 != '0) && (x_s4 < thr_s4[7])) ? {1'b0, bar_cnt_c} : 4'd8;

		bar_sep_end_c = 12'(bar_h_s4) + 12'd4;
		black_c = (y_s4 < 12'd4) || ((13'(y_s4) + 13'd4) >= h_s4) ||
			(x_s4 < 12'd4) || ((13'(x_s4) + 13'd4) >= w_s4) ||
			((y_s4 >= 12'(bar_h_s4)) && (y_s4 < bar_sep_end_c)) ||
			((y_s4 >= ramp_end_s4) && (y_s4 < (ramp_end_s4 + 12'd4)));

		gy_c = in_grad_c ? (y_s4 - grad_y0_s4) : 12'd0;
	end

	logic [COORD_W-1:0] x_s5;
	logic [DIM_W-1:0]   w_s5;
	logic [FMT_W-1:0]   fmt_s5;
	logic               infr_s5;
	logic [19:0]        xm_s5;
	logic [11:0]        wm1_s5;
	logic [11:0]        gy_s5, grad_h_s5;
	logic [1:0]         region_s5, sel_s5;
	logic [3:0]         bar_idx_s5;
	logic               black_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5       <= x_s4;
			w_s5       <= w_s4;
			fmt_s5     <= fmt_s4;
			infr_s5    <= infr_s4;
			xm_s5      <= xm_s4;
			wm1_s5     <= wm1_s4;
			gy_s5      <= gy_c;
			grad_h_s5  <= grad_h_c;
			region_s5  <= region_c;
			sel_s5     <= sel_c;
			bar_idx_s5 <= bar_idx_c;
			black_s5   <= black_c;
		end
	end

	// ------------------------------------------------------------------
	// s6: divider operands
	//   V: x*255 / (w-1)            horizontal ramp value
	//   G: gy*255 / (gh-1)          gradient green
	//   B: (x+gy)*255 / (w+gh-2)    gradient blue, inverted later
	// ------------------------------------------------------------------
	logic [12:0] xg_c;
	logic [13:0] wg_c;
	div_lane_t [NLANE-1:0] lanes_c;
	pix_side_t side_c;

	always_comb begin
		xg_c = 13'(x_s5) + 13'(gy_s5);
		wg_c = 14'(w_s5) + 14'(grad_h_s5);

		lanes_c[LANE_V].dvd = DVD_W'(xm_s5);
		lanes_c[LANE_V].dvs = DVS_W'(wm1_s5);
		lanes_c[LANE_G].dvd = DVD_W'(gy_s5) * DVD_W'(255);
		lanes_c[LANE_G].dvs = (grad_h_s5 <= 12'd1) ? DVS_W'(1) : DVS_W'(grad_h_s5 - 12'd1);
		lanes_c[LANE_B].dvd = DVD_W'(xg_c) * DVD_W'(255);
		lanes_c[LANE_B].dvs = (wg_c <= 14'd2) ? DVS_W'(1) : DVS_W'(wg_c - 14'd2);

		side_c.fmt      = fmt_s5;
		side_c.in_frame = infr_s5;
		side_c.black    = black_s5;
		side_c.region   = region_s5;
		side_c.bar_idx  = bar_idx_s5;
		side_c.ramp_sel = sel_s5;
	end

	div_lane_t [NLANE-1:0] lanes_s6;
	pix_side_t             side_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_s6 <= lanes_c;
			side_s6  <= side_c;
		end
	end

	// ------------------------------------------------------------------
	// s7..s14: divider
	// ------------------------------------------------------------------
	logic                         dv_vld;
	logic [NLANE-1:0][Q_BITS-1:0] dv_quo;
	pix_side_t                    dv_side;

	ctp_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s6),
		.lanes_in (lanes_s6),
		.side_in  (side_s6),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	// ------------------------------------------------------------------
	// s15: color select, black overlay, luma weighted sum
	// ------------------------------------------------------------------
	logic [7:0]  r_c, g_c, b_c;
	logic [14:0] luma_sum_c;

	always_comb begin
		r_c = 8'hFF;
		g_c = 8'hFF;
		b_c = 8'hFF;
		case (dv_side.region)
		REGION_BAR: begin
			{r_c, g_c, b_c} = bar_rgb(dv_side.bar_idx);
		end
		REGION_RAMP: begin
			r_c = 8'h00;
			g_c = 8'h00;
			b_c = 8'h00;
			case (dv_side.ramp_sel)
			SEL_R:   r_c = dv_quo[LANE_V];
			SEL_G:   g_c = dv_quo[LANE_V];
			default: b_c = dv_quo[LANE_V]; // blue third
			endcase
		end
		REGION_GRAD: begin
			r_c = dv_quo[LANE_V];
			g_c = dv_quo[LANE_G];
			b_c = ~dv_quo[LANE_B]; // 255 - q
		end
		default: ; // white background
		endcase
		if (dv_side.black) begin
			r_c = 8'h00;
			g_c = 8'h00;
			b_c = 8'h00;
		end
		luma_sum_c = 15'(r_c) * 15'd30 + 15'(g_c) * 15'd59 + 15'(b_c) * 15'd11;
	end

	logic [23:0]      rgb_s15;
	logic [14:0]      luma_sum_s15;
	logic [FMT_W-1:0] fmt_s15;
	logic             infr_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s15      <= {r_c, g_c, b_c};
			luma_sum_s15 <= luma_sum_c;
			fmt_s15      <= dv_side.fmt;
			infr_s15     <= dv_side.in_frame;
		end
	end

	// ------------------------------------------------------------------
	// s16: luma divide by 100 and pack; output register
	// ------------------------------------------------------------------
	logic [33:0] luma_prod;
	logic [7:0]  luma_c;
	logic [31:0] word_c;

	always_comb begin
		luma_prod = 34'(luma_sum_s15) * 34'(DIV100_K);
		luma_c    = luma_prod[DIV100_SH +: 8];
		case (fmt_s15)
		FMT_RGB32:  word_c = {8'hFF, rgb_s15};
		FMT_RGB565: word_c = {16'h0000, rgb_s15[23:19], rgb_s15[15:10], rgb_s15[7:3]};
		default:    word_c = {4{luma_c}}; // luma in every byte
		endcase
		if (!infr_s15) begin
			word_c = '0;
		end
	end

	logic [31:0] word_s16;
	logic        infr_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s16 <= word_c;
			infr_s16 <= infr_s15;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= coord.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s15 <= dv_vld;
			vld_s16 <= vld_s15;
		end
	end

	assign pixel.valid      = vld_s16;
	assign pixel.pixel_word = word_s16;
	assign pixel.in_frame   = infr_s16;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a waiting result must block new transactions
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.ready) |-> !coord.ready)
		else $error("coord accepted while result stalled");

	// a stall must freeze the color stage
	a_stall_holds_s15: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_s15) && (!vld_s15 || $stable(rgb_s15))))
		else $error("color stage moved during stall");

	// bar, ramp and gradient rows never overlap
	a_regions_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> $onehot0({in_bar_c, in_ramp_c, in_grad_c}))
		else $error("row regions overlap");

endmodule

@@ tb/sv/color_test_pattern_pixel_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_test_pattern_pixel_unit_tb: self-checking bench of the pattern unit
// Streams pixel coordinates through the coord channel under several frame
// sizes and pixel formats and checks every pixel transaction against a
// behavioral model of the test frame. Random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module color_test_pattern_pixel_unit_tb;
	import ctp_pkg::*;

	// drain margin on top of the unit's pipe depth before a register write
	localparam int PIPE_LATENCY = 16;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;

	// codes with no name in the package
	localparam logic [FMT_W-1:0] FMT_LUMA     = 2'd2;
	localparam logic [FMT_W-1:0] FMT_LUMA_ALT = 2'd3; // also packs luma
	localparam logic [IDX_W-1:0] REG_UNUSED   = 2'd3; // writes are dropped

	// 0xRRGGBB of the nine bars, index 0 (white) in the low bits
	localparam logic [8:0][23:0] BAR_COLORS = {
		24'h808080, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h0000FF,
		24'h00FF00, 24'hFF0000, 24'h000000, 24'hFFFFFF
	};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} coord_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic        in_frame;
	} pixel_result_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [DIM_W-1:0] wr_data;

	ctp_coord_if coord ();
	ctp_pixel_if pixel ();

	color_test_pattern_pixel_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coord    (coord.sink),
		.pixel    (pixel.source)
	);

	// bench copy of the frame registers, raw as written
	logic [DIM_W-1:0] cfg_width  = RST_WIDTH;
	logic [DIM_W-1:0] cfg_height = RST_HEIGHT;
	logic [FMT_W-1:0] cfg_format = FMT_RGB32;

	coord_item_t   pending_coords[$];  // coordinates not yet offered
	pixel_result_t expected_pixels[$]; // pixels owed by the unit, oldest first

	int unsigned mismatch_count = 0;
	bit          idle_on = 1'b1;       // random gaps/stalls enabled
	int unsigned src_gap = 0;
	int unsigned sink_stall = 0;

	// ------------------------------------------------------------------------
	// Clock and timeout
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// timeout set well beyond the worst correct run
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model of the test frame
	// ------------------------------------------------------------------------
	function automatic int unsigned or_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		int unsigned w, h, x, y, r, g, b;
		int unsigned bar_h, ramp_y0, ramp_h, ramp_end, grad_y0, grad_h;
		int unsigned bw, idx, v, ry, gy, luma;
		logic [23:0] rgb;
		pixel_result_t res;
		res = '0;
		// oversized dimensions saturate
		w = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
		h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
		x = px;
		y = py;
		// outside the frame: flag low, zero word (also covers zero sizes)
		if (x >= w || y >= h)
			return res;

		r = 255;
		g = 255;
		b = 255;
		bar_h    = h * 38 / 100;
		ramp_y0  = bar_h + 40;
		ramp_h   = h * 15 / 100;
		ramp_end = ramp_y0 + ramp_h;
		grad_y0  = ramp_end + 50;
		grad_h   = (h > grad_y0 + 81) ? h - grad_y0 - 80 : 1;

		if (y < bar_h) begin
			// narrow frame: bar width 0 puts everything in the gray bar
			bw  = w / 9;
			idx = (bw != 0 && x < 8 * bw) ? x / bw : 8;
			rgb = BAR_COLORS[idx];
			r = rgb[23:16];
			g = rgb[15:8];
			b = rgb[7:0];
		end else if (y >= ramp_y0 && y < ramp_end) begin
			ry = y - ramp_y0;
			v  = x * 255 / or_one(w - 1);
			r = 0;
			g = 0;
			b = 0;
			if (ry < ramp_h / 3)
				r = v;
			else if (ry < 2 * ramp_h / 3)
				g = v;
			else
				b = v;
		end else if (y >= grad_y0 && y < grad_y0 + grad_h) begin
			gy = y - grad_y0;
			r = x * 255 / or_one(w - 1);
			g = gy * 255 / or_one(grad_h - 1);
			b = 255 - ((x + gy) * 255 / or_one(w + grad_h - 2));
		end

		// border and the two separators are drawn over everything
		if (y < 4 || y + 4 >= h || x < 4 || x + 4 >= w ||
				(y >= bar_h && y < bar_h + 4) ||
				(y >= ramp_end && y < ramp_end + 4)) begin
			r = 0;
			g = 0;
			b = 0;
		end

		case (cfg_format)
		FMT_RGB32: res.word = {8'hFF, r[7:0], g[7:0], b[7:0]};
		FMT_RGB565: res.word = {16'h0000, r[7:3], g[7:2], b[7:3]};
		default: begin
			luma = (30 * r + 59 * g + 11 * b) / 100;
			res.word = {4{luma[7:0]}};
		end
		endcase
		res.in_frame = 1'b1;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic add_coord(input int x, input int y);
		coord_item_t item;
		item.x = x[COORD_W-1:0];
		item.y = y[COORD_W-1:0];
		pending_coords.push_back(item);
	endtask

	// registers are only touched once the pipe is empty
	task automatic wait_drained();
		while (pending_coords.size() != 0 || coord.valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
		REG_WIDTH: cfg_width = val;
		REG_HEIGHT: cfg_height = val;
		REG_FORMAT: cfg_format = val[FMT_W-1:0];
		default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h,
			input logic [FMT_W-1:0] fmt);
		wait_drained();
		write_reg(REG_WIDTH, w[DIM_W-1:0]);
		write_reg(REG_HEIGHT, h[DIM_W-1:0]);
		write_reg(REG_FORMAT, {{(DIM_W-FMT_W){1'b0}}, fmt});
	endtask

	// Random coordinates for the current frame: mostly in frame, a good share
	// pinned near region edges (bar/ramp/gradient rows, bar columns, border),
	// and some over the full 12-bit range so every input bit toggles.
	task automatic queue_random(input int count);
		int unsigned w, h, bw;
		int marks[6];
		int xs, ys, k, j;
		w  = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
		h  = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
		bw = w / 9;
		marks[0] = h * 38 / 100;
		marks[1] = marks[0] + 40;
		marks[2] = marks[1] + h * 15 / 100;
		marks[3] = marks[2] + 50;
		marks[4] = int'(h) - 80;
		marks[5] = int'(h) - 4;
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (w == 0 || h == 0 || k < 15) begin
				xs = $urandom_range(0, 4095);
				ys = $urandom_range(0, 4095);
			end else begin
				if (k < 45)
					ys = marks[$urandom_range(0, 5)] + int'($urandom_range(0, 9)) - 5;
				else
					ys = $urandom_range(0, h - 1);
				j = $urandom_range(0, 9);
				if (j < 2)
					xs = int'($urandom_range(0, 9) * bw) + int'($urandom_range(0, 7)) - 4;
				else if (j == 2)
					xs = $urandom_range(0, 1) ? int'($urandom_range(0, 7))
						: int'(w) - 1 - int'($urandom_range(0, 7));
				else
					xs = $urandom_range(0, w - 1);
				if (xs < 0)
					xs = 0;
				if (xs >= int'(w))
					xs = w - 1;
				if (ys < 0)
					ys = 0;
				if (ys >= int'(h))
					ys = h - 1;
			end
			add_coord(xs, ys);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: offers queued coordinates, with random gap bursts. Every
	// accepted coord transaction gets its expected pixel at that edge; the
	// registers cannot change while anything is in flight.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		coord_item_t nxt;
		if (!arst_n) begin
			coord.valid   <= 1'b0;
			coord.pixel_x <= '0;
			coord.pixel_y <= '0;
			src_gap       <= 0;
		end else begin
			if (coord.valid && coord.ready)
				expected_pixels.push_back(predict_pixel(coord.pixel_x, coord.pixel_y));
			// a held item stays put until it is taken
			if (!coord.valid || coord.ready) begin
				if (src_gap != 0) begin
					coord.valid <= 1'b0;
					src_gap     <= src_gap - 1;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					coord.valid <= 1'b0;
					src_gap     <= $urandom_range(0, 15);
				end else if (pending_coords.size() != 0) begin
					nxt = pending_coords.pop_front();
					coord.valid   <= 1'b1;
					coord.pixel_x <= nxt.x;
					coord.pixel_y <= nxt.y;
				end else begin
					coord.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each pixel transaction against the oldest expectation,
	// and throttles ready in random stall bursts.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_px;
		if (!arst_n) begin
			pixel.ready <= 1'b0;
			sink_stall  <= 0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel word=%h in_frame=%b",
						pixel.pixel_word, pixel.in_frame));
				end else begin
					exp_px = expected_pixels.pop_front();
					if (pixel.pixel_word !== exp_px.word)
						report_mismatch($sformatf("pixel_word got %h want %h",
							pixel.pixel_word, exp_px.word));
					if (pixel.in_frame !== exp_px.in_frame)
						report_mismatch($sformatf("in_frame got %b want %b",
							pixel.in_frame, exp_px.in_frame));
				end
			end
			if (sink_stall != 0) begin
				pixel.ready <= 1'b0;
				sink_stall  <= sink_stall - 1;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				pixel.ready <= 1'b0;
				sink_stall  <= $urandom_range(0, 15);
			end else begin
				pixel.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned rw, rh;
		// config port known from time zero; channel signals come from the
		// driver and monitor reset branches
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_WIDTH;
		wr_data       = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset frame 1024x768 RGB32 (bars 113 wide; bars fill rows
		// 0..290, ramps 331..445, gradient 496..687).
		add_coord(0, 0);
		add_coord(4095, 4095);
		add_coord(1023, 767);    // last pixel, border
		add_coord(1024, 10);     // one column past the frame
		add_coord(10, 768);      // one row past the frame
		add_coord(3, 100);       // left border edge
		add_coord(4, 100);
		add_coord(1019, 100);
		add_coord(1020, 100);    // right border edge
		for (int i = 0; i < 9; i++)
			add_coord(60 + 113 * i, 100); // one pixel inside each bar
		add_coord(500, 293);     // separator under the bars
		add_coord(512, 340);     // red ramp
		add_coord(512, 380);     // green ramp
		add_coord(1018, 430);    // blue ramp, near full scale
		add_coord(512, 447);     // separator under the ramps
		add_coord(5, 496);       // gradient, first row
		add_coord(1018, 687);    // gradient, last row
		add_coord(512, 700);     // white background below
		queue_random(150);

		// largest frame, 565 packing
		set_frame(4096, 4096, FMT_RGB565);
		queue_random(200);

		// smallest legal frame: one row, nine columns, all border
		set_frame(9, 1, FMT_LUMA);
		queue_random(80);

		// oversized sizes saturate; format 3 packs luma; unused index ignored
		set_frame(8191, 5000, FMT_LUMA_ALT);
		write_reg(REG_UNUSED, 13'h1FFF);
		queue_random(150);

		// zero width, then zero height: nothing is in frame
		set_frame(0, 768, FMT_RGB32);
		queue_random(40);
		set_frame(800, 0, FMT_RGB565);
		queue_random(40);

		// narrow frame: gray bar covers the whole bar area
		set_frame(5, 300, FMT_RGB32);
		queue_random(100);

		// random geometries; one of them without gaps or stalls
		for (int p = 0; p < 4; p++) begin
			rw = $urandom_range(9, 4096);
			rh = $urandom_range(1, 4096);
			set_frame(rw, rh, FMT_W'($urandom_range(0, 3)));
			idle_on = (p != 2);
			queue_random(120);
		end

		// last part at full rate
		set_frame(1920, 1080, FMT_RGB32);
		idle_on = 1'b0;
		queue_random(250);

		wait_drained();
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ctp_pkg.sv
hw/rtl/ctp_if.sv
hw/rtl/ctp_div_pipe.sv
hw/rtl/color_test_pattern_pixel_unit.sv
tb/sv/color_test_pattern_pixel_unit_tb.sv
